// ===== rtl/mimp_pkg.sv =====
// Shared types, codes and helpers of the MIDI input message parser.
`timescale 1ns / 1ps

package mimp_pkg;

    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 7;
    localparam int MASK_W   = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BYTE_W-1:0] ST_SYSEX    = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_SONG_SEL = 8'hF3;
    localparam logic [BYTE_W-1:0] ST_EOX      = 8'hF7;
    localparam logic [BYTE_W-1:0] ST_ALIVE    = 8'hFE;

    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CTRL       = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    localparam logic REG_RECORD_ENABLE = 1'b0;
    localparam logic REG_CHANNEL_MASK  = 1'b1;

    localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_CHANNEL    = 2'd0,
        KIND_SYSEX_DATA = 2'd1,
        KIND_SYSEX_END  = 2'd2,
        KIND_ALIVE      = 2'd3
    } t_kind;

    typedef struct packed {
        logic              record_enable;
        logic [MASK_W-1:0] channel_mask;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] msg_status;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
        logic              store;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_beat;

    function automatic logic [1:0] data_count(input logic [BYTE_W-1:0] status);
        logic [1:0] cnt;
        unique case (status[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH_BEND: cnt = 2'd2;
            HI_PROGRAM, HI_CHAN_PRESS: cnt = 2'd1;
            default: cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

// ===== rtl/mimp_if.sv =====
// Handshake channels for raw MIDI bytes and parsed message beats.
`timescale 1ns / 1ps

interface mimp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink (input valid, input midi_byte, output ready);
endinterface

interface mimp_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] msg_status;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       store;

    modport source (
        output valid, output kind, output msg_status, output first_data,
        output second_data, output store, input ready
    );
    modport sink (
        input valid, input kind, input msg_status, input first_data,
        input second_data, input store, output ready
    );
endinterface

// ===== rtl/mimp_cfg_regs.sv =====
// APB configuration registers: record enable and channel mask.
`timescale 1ns / 1ps

module mimp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mimp_pkg::APB_AW-1:0]   paddr,
    input  logic [mimp_pkg::APB_DW-1:0]   pwdata,
    output logic [mimp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output mimp_pkg::t_cfg                o_cfg
);
    import mimp_pkg::*;

    logic              r_record_enable;
    logic [MASK_W-1:0] r_channel_mask;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_enable <= 1'b0;
            r_channel_mask  <= MASK_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RECORD_ENABLE: r_record_enable <= pwdata[0];
                REG_CHANNEL_MASK:  r_channel_mask  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RECORD_ENABLE: prdata = {{(APB_DW-1){1'b0}}, r_record_enable};
            REG_CHANNEL_MASK:  prdata = {{(APB_DW-MASK_W){1'b0}}, r_channel_mask};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.record_enable = r_record_enable;
    assign o_cfg.channel_mask  = r_channel_mask;

endmodule

// ===== rtl/mimp_parser.sv =====
// Running-status parse state and per-byte decode into one result beat.
`timescale 1ns / 1ps

module mimp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [mimp_pkg::BYTE_W-1:0]   i_byte,
    input  mimp_pkg::t_cfg                i_cfg,
    output mimp_pkg::t_beat               o_beat
);
    import mimp_pkg::*;

    logic [BYTE_W-1:0] r_running_status, n_running_status;
    logic [1:0]        r_bytes_remaining, n_bytes_remaining;
    logic              r_awaiting_data, n_awaiting_data;
    logic [DATA_W-1:0] r_held_data, n_held_data;
    logic              r_sysex_active, n_sysex_active;
    logic              r_skip_next, n_skip_next;

    logic [1:0]        need;
    logic [1:0]        rs_count;
    logic              rs_two;
    t_beat             beat;

    assign rs_count = data_count(r_running_status);
    assign rs_two   = (rs_count == 2'd2);
    assign need     = r_awaiting_data ? r_bytes_remaining : rs_count;

    always_comb begin
        n_running_status  = r_running_status;
        n_bytes_remaining = r_bytes_remaining;
        n_awaiting_data   = r_awaiting_data;
        n_held_data       = r_held_data;
        n_sysex_active    = r_sysex_active;
        n_skip_next       = r_skip_next;
        beat              = '0;

        if (r_skip_next) begin
            n_skip_next = 1'b0;
        end else if (i_byte[7:4] == HI_SYSTEM) begin
            priority case (i_byte)
                ST_SYSEX:    n_sysex_active = 1'b1;
                ST_SONG_SEL: n_skip_next    = 1'b1;
                ST_EOX: begin
                    n_sysex_active          = 1'b0;
                    beat.valid              = 1'b1;
                    beat.result.kind        = KIND_SYSEX_END;
                    beat.result.msg_status  = ST_EOX;
                end
                ST_ALIVE: begin
                    beat.valid              = 1'b1;
                    beat.result.kind        = KIND_ALIVE;
                    beat.result.msg_status  = ST_ALIVE;
                end
                default: ;
            endcase
        end else if (i_byte[7]) begin
            if (r_sysex_active) begin
                n_sysex_active          = 1'b0;
                beat.valid              = 1'b1;
                beat.result.kind        = KIND_SYSEX_END;
                beat.result.msg_status  = ST_EOX;
            end
            n_running_status  = i_byte;
            n_bytes_remaining = data_count(i_byte);
            n_awaiting_data   = (data_count(i_byte) != 2'd0);
        end else if (r_sysex_active) begin
            beat.valid              = 1'b1;
            beat.result.kind        = KIND_SYSEX_DATA;
            beat.result.msg_status  = ST_SYSEX;
            beat.result.first_data  = i_byte[DATA_W-1:0];
        end else if (need != 2'd0) begin
            if (need >= 2'd2) begin
                n_held_data       = i_byte[DATA_W-1:0];
                n_bytes_remaining = 2'd1;
                n_awaiting_data   = 1'b1;
            end else begin
                n_bytes_remaining       = 2'd0;
                n_awaiting_data         = 1'b0;
                beat.valid              = 1'b1;
                beat.result.kind        = KIND_CHANNEL;
                beat.result.msg_status  = r_running_status;
                beat.result.first_data  = rs_two ? r_held_data : i_byte[DATA_W-1:0];
                beat.result.second_data = rs_two ? i_byte[DATA_W-1:0] : '0;
                beat.result.store       = i_cfg.record_enable
                                        & i_cfg.channel_mask[r_running_status[3:0]];
            end
        end else begin
            n_bytes_remaining = need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status  <= '0;
            r_bytes_remaining <= '0;
            r_awaiting_data   <= 1'b0;
            r_held_data       <= '0;
            r_sysex_active    <= 1'b0;
            r_skip_next       <= 1'b0;
        end else if (i_advance) begin
            r_running_status  <= n_running_status;
            r_bytes_remaining <= n_bytes_remaining;
            r_awaiting_data   <= n_awaiting_data;
            r_held_data       <= n_held_data;
            r_sysex_active    <= n_sysex_active;
            r_skip_next       <= n_skip_next;
        end
    end

    assign o_beat = beat;

endmodule

// ===== rtl/midi_input_message_parser_unit.sv =====
// Top level: input byte register, parser, result register and APB registers.
`timescale 1ns / 1ps

// Takes one MIDI byte per cycle and rebuilds channel messages with running
// status, reports sysex data and end beats and active-sensing marks. A byte
// is accepted every cycle while the result register is free or being
// drained. Each byte is held in the input byte register, decoded
// combinationally, and any beat goes to the result register, where it can
// be taken at the following edge. Configuration is written through the APB
// port; the user must do this only while the unit is idle (not enforced).
module midi_input_message_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mimp_byte_if.sink                     i_byte,
    mimp_msg_if.source                    o_msg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mimp_pkg::APB_AW-1:0]   paddr,
    input  logic [mimp_pkg::APB_DW-1:0]   pwdata,
    output logic [mimp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mimp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              in_ready;
    t_cfg              cfg;
    t_beat             beat;

    mimp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mimp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_cfg     (cfg),
        .o_beat    (beat)
    );

    assign advance  = r_in_valid && (!r_out_valid || o_msg.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_byte.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.midi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= beat.valid;
        end else if (o_msg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && beat.valid) begin
            r_out <= beat.result;
        end
    end

    assign o_msg.valid       = r_out_valid;
    assign o_msg.kind        = r_out.kind;
    assign o_msg.msg_status  = r_out.msg_status;
    assign o_msg.first_data  = r_out.first_data;
    assign o_msg.second_data = r_out.second_data;
    assign o_msg.store       = r_out.store;

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_byte.ready)
        else $error("input not ready while result register is free");

    a_hold_stalled_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_msg.ready) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");

    a_store_only_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && (o_msg.kind != KIND_CHANNEL)) |-> !o_msg.store)
        else $error("store flag on non-channel beat");

    a_sysex_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && (o_msg.kind == KIND_SYSEX_END)) |->
            ((o_msg.msg_status == ST_EOX) && (o_msg.first_data == '0)))
        else $error("malformed sysex end beat");

endmodule

// ===== tb/sv/midi_input_message_parser_unit_tb.sv =====
// Self-checking testbench for the MIDI input message parser: directed and random byte streams.
`timescale 1ns / 1ps

module midi_input_message_parser_unit_tb;
    import mimp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_SETTING = 78;
    localparam logic [APB_AW-1:0] ADDR_RECORD_ENABLE = {REG_RECORD_ENABLE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_CHANNEL_MASK = {REG_CHANNEL_MASK, 2'b00};

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    mimp_byte_if byte_ch ();
    mimp_msg_if msg_ch ();

    midi_input_message_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_msg   (msg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic              cfg_record = 1'b0;
    logic [MASK_W-1:0] cfg_mask = MASK_RESET;

    logic [BYTE_W-1:0] rs_status = '0;
    logic [1:0]        rs_remaining = '0;
    logic              rs_awaiting = 1'b0;
    logic [DATA_W-1:0] rs_held = '0;
    logic              rs_sysex = 1'b0;
    logic              rs_skip = 1'b0;

    t_result expected_msgs[$];
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      msgs_checked = 0;
    int      settings_applied = 0;
    int      kind_seen[4] = '{0, 0, 0, 0};
    int      cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("midi_input_message_parser_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [1:0] msg_data_len(input logic [BYTE_W-1:0] status);
        case (status[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH_BEND: return 2'd2;
            HI_PROGRAM, HI_CHAN_PRESS: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic predict_midi_byte(input logic [BYTE_W-1:0] b, output t_result res);
        logic had_sysex;
        logic two;
        res = '0;
        if (rs_skip) begin
            rs_skip = 1'b0;
            return 1'b0;
        end
        if (b >= ST_SYSEX) begin
            if (b == ST_SYSEX) begin
                rs_sysex = 1'b1;
            end else if (b == ST_SONG_SEL) begin
                rs_skip = 1'b1;
            end else if (b == ST_EOX) begin
                rs_sysex = 1'b0;
                res.kind = KIND_SYSEX_END;
                res.msg_status = ST_EOX;
                return 1'b1;
            end else if (b == ST_ALIVE) begin
                res.kind = KIND_ALIVE;
                res.msg_status = ST_ALIVE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b[7]) begin
            had_sysex = rs_sysex;
            if (rs_sysex) begin
                res.kind = KIND_SYSEX_END;
                res.msg_status = ST_EOX;
            end
            rs_sysex = 1'b0;
            rs_status = b;
            rs_remaining = msg_data_len(b);
            rs_awaiting = (rs_remaining != 2'd0);
            return had_sysex;
        end
        if (rs_sysex) begin
            res.kind = KIND_SYSEX_DATA;
            res.msg_status = ST_SYSEX;
            res.first_data = b[DATA_W-1:0];
            return 1'b1;
        end
        if (!rs_awaiting) begin
            rs_remaining = msg_data_len(rs_status);
            if (rs_remaining == 2'd0) begin
                return 1'b0;
            end
            rs_awaiting = 1'b1;
        end
        if (rs_remaining >= 2'd2) begin
            rs_held = b[DATA_W-1:0];
            rs_remaining = 2'd1;
            return 1'b0;
        end
        two = (msg_data_len(rs_status) == 2'd2);
        res.kind = KIND_CHANNEL;
        res.msg_status = rs_status;
        res.first_data = two ? rs_held : b[DATA_W-1:0];
        res.second_data = two ? b[DATA_W-1:0] : '0;
        res.store = cfg_record & cfg_mask[rs_status[3:0]];
        rs_remaining = 2'd0;
        rs_awaiting = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_msgs
        t_result want;
        msg_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        if (i_rst_n && msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) begin
            if (expected_msgs.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual kind %0d status 0x%0h",
                         $time, msg_ch.kind, msg_ch.msg_status);
                mismatch_count++;
            end else begin
                want = expected_msgs.pop_front();
                check_field("kind", 8'(want.kind), 8'(msg_ch.kind));
                check_field("msg_status", want.msg_status, msg_ch.msg_status);
                check_field("first_data", 8'(want.first_data), 8'(msg_ch.first_data));
                check_field("second_data", 8'(want.second_data), 8'(msg_ch.second_data));
                check_field("store", 8'(want.store), 8'(msg_ch.store));
                kind_seen[want.kind]++;
                msgs_checked++;
            end
        end
    end

    task automatic push_midi_byte(input logic [BYTE_W-1:0] b);
        t_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.midi_byte <= b;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        if (predict_midi_byte(b, res)) begin
            expected_msgs.push_back(res);
        end
        bytes_sent++;
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_back_config();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, ADDR_RECORD_ENABLE, '0, rd);
        if (rd[0] !== cfg_record) begin
            $display("%0t: record_enable readback, expected %0d actual %0d",
                     $time, cfg_record, rd[0]);
            mismatch_count++;
        end
        apb_access(1'b0, ADDR_CHANNEL_MASK, '0, rd);
        if (rd[MASK_W-1:0] !== cfg_mask) begin
            $display("%0t: channel_mask readback, expected 0x%0h actual 0x%0h",
                     $time, cfg_mask, rd[MASK_W-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic apply_config(input logic rec, input logic [MASK_W-1:0] mask);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_access(1'b1, ADDR_RECORD_ENABLE, APB_DW'(rec), rd);
        apb_access(1'b1, ADDR_CHANNEL_MASK, APB_DW'(mask), rd);
        cfg_record = rec;
        cfg_mask = mask;
        settings_applied++;
        read_back_config();
    endtask

    task automatic send_channel_msg();
        logic [3:0] hi;
        logic [3:0] ch;
        int n;
        if ($urandom_range(3) != 0 || rs_status == '0) begin
            hi = 4'($urandom_range(HI_NOTE_OFF, HI_PITCH_BEND));
            ch = 4'($urandom_range(15));
            push_midi_byte({hi, ch});
        end
        n = msg_data_len(rs_status);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                hi = 4'($urandom_range(15));
                push_midi_byte((hi == 4'h3 || hi == 4'h7 || hi == 4'h0) ? ST_ALIVE
                                                                        : {HI_SYSTEM, hi});
            end
            push_midi_byte(8'($urandom_range(127)));
        end
    endtask

    task automatic send_sysex_stream();
        int n;
        int ending;
        push_midi_byte(ST_SYSEX);
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            push_midi_byte(8'($urandom_range(127)));
        end
        ending = $urandom_range(9);
        if (ending < 6) begin
            push_midi_byte(ST_EOX);
        end else if (ending < 8) begin
            push_midi_byte(8'($urandom_range(8'h80, 8'hEF)));
        end else begin
            push_midi_byte(ST_SONG_SEL);
            push_midi_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_traffic(input int n_items);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_channel_msg();
            end else if (pick < 70) begin
                send_sysex_stream();
            end else if (pick < 78) begin
                push_midi_byte(ST_ALIVE);
            end else if (pick < 85) begin
                push_midi_byte(ST_SONG_SEL);
                push_midi_byte(8'($urandom_range(255)));
            end else if (pick < 93) begin
                push_midi_byte(8'($urandom_range(8'h80, 8'hEF)));
                push_midi_byte(8'($urandom_range(127)));
            end else begin
                push_midi_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct, inout int step);
        logic [MASK_W-1:0] rmask;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < 3; k++) begin
            rmask = MASK_W'($urandom_range(16'hFFFF));
            case (step % 6)
                0: apply_config(1'b1, 16'hFFFF);
                1: apply_config(1'b1, 16'h0000);
                2: apply_config(1'b1, rmask);
                3: apply_config(1'b0, rmask);
                4: apply_config(1'b1, 16'h8001);
                default: apply_config(1'b0, 16'hFFFF);
            endcase
            step++;
            send_random_traffic(ITEMS_PER_SETTING);
        end
    endtask

    task automatic test_register_defaults();
        wait_idle();
        read_back_config();
    endtask

    task automatic test_directed_stream();
        logic [BYTE_W-1:0] stream[$];
        src_idle_pct = 14;
        snk_idle_pct = 76;
        stream = '{8'h45, 8'h80, 8'h00, 8'h7F, 8'h7F, 8'hF8, 8'h01, 8'hC3, 8'h7F,
                   8'h9F, 8'h3C, ST_SYSEX, 8'h7F, ST_SONG_SEL, ST_EOX, ST_EOX, 8'h40,
                   ST_EOX, ST_ALIVE, ST_SYSEX, 8'h00, 8'hB2, 8'h07, 8'hE5, 8'h00, 8'h40,
                   8'hD1, 8'h20, 8'hA4, 8'h10, 8'h20, ST_SONG_SEL, 8'h90, 8'hFF};
        foreach (stream[i]) begin
            push_midi_byte(stream[i]);
        end
    endtask

    task automatic test_random_sender_stalls(inout int step);
        run_random_phase(14, 76, step);
    endtask

    task automatic test_random_receiver_stalls(inout int step);
        run_random_phase(76, 14, step);
    endtask

    task automatic test_random_no_stalls(inout int step);
        run_random_phase(0, 0, step);
    endtask

    initial begin : main_seq
        int cfg_step;
        cfg_step = 0;
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.midi_byte <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_defaults();
        test_directed_stream();
        test_random_sender_stalls(cfg_step);
        test_random_receiver_stalls(cfg_step);
        test_random_no_stalls(cfg_step);
        wait_idle();

        $display("Sent %0d MIDI bytes under %0d register settings; checked %0d beats.",
                 bytes_sent, settings_applied, msgs_checked);
        $display("Beats by kind: channel %0d, sysex data %0d, sysex end %0d, alive %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (mismatch_count == 0 && expected_msgs.size() == 0) begin
            $display("midi_input_message_parser_unit_tb OK");
        end else begin
            $display("midi_input_message_parser_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
